[hdl/ecdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdt_pkg
// Shared commands, status codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package ecdt_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned SlotW = 4;
  localparam int unsigned DelayW = 32;
  localparam int unsigned DeadlineW = 64;
  localparam int unsigned RevW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned HighCountW = 32;

  localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
  localparam logic [CmdW-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CmdW-1:0] CMD_CANCEL = 2'd2;
  localparam logic [CmdW-1:0] CMD_READ = 2'd3;

  localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [StatusW-1:0] ST_PASSED = 3'd1;
  localparam logic [StatusW-1:0] ST_STALE = 3'd2;
  localparam logic [StatusW-1:0] ST_BUSY = 3'd3;
  localparam logic [StatusW-1:0] ST_CANCELLED = 3'd4;
  localparam logic [StatusW-1:0] ST_NOT_PENDING = 3'd5;
  localparam logic [StatusW-1:0] ST_COUNT = 3'd6;
  localparam logic [StatusW-1:0] ST_EXPIRED = 3'd7;

  localparam logic CFG_CLOCK_REVISION = 1'b0;
  localparam logic CFG_KEEP_RUNNING = 1'b1;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [SlotW-1:0] slot;
    logic [DelayW-1:0] delay;
    logic [DeadlineW-1:0] deadline;
    logic rev_ok;
  } cmd_word_t;

endpackage

[hdl/extended_counter_deadline_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_counter_deadline_timer
// Deadline timer with a merged extended tick count and a slot table.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// in_       input      cmd, slot, delay, deadline, request_revision
// out_      output     status, slot_out, count_value, last
// cfg_      input      index, data
//
// Request, cancel and read pass through the queue and then execute in the back
// end. A tick runs the deadline scan, one slot per cycle, and scans again after
// each expiring slot it finds, up to the sixteenth. An expiry word waits in a
// staging register until the next scan shows whether another one follows.
// Reset is synchronous and needs no clearing pass. A two-word queue lets input
// arrive while the back end waits on output.
module extended_counter_deadline_timer #(
  parameter int SLOTS = 16,
  parameter int LOW_COUNT_WIDTH = 24
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [ecdt_pkg::CmdW-1:0]                      in_cmd,
  input  logic [ecdt_pkg::SlotW-1:0]                     in_slot,
  input  logic [ecdt_pkg::DelayW-1:0]                    in_delay,
  input  logic [ecdt_pkg::DeadlineW-1:0]                 in_deadline,
  input  logic [ecdt_pkg::RevW-1:0]                      in_request_revision,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [ecdt_pkg::StatusW-1:0]                   out_status,
  output logic [ecdt_pkg::SlotW-1:0]                     out_slot_out,
  output logic [LOW_COUNT_WIDTH+ecdt_pkg::HighCountW-1:0] out_count_value,
  output logic                                           out_last,
  input  logic                                           cfg_valid,
  output logic                                           cfg_ready,
  input  logic                                           cfg_index,
  input  logic [ecdt_pkg::RevW-1:0]                      cfg_data
);

  logic [ecdt_pkg::RevW-1:0] rev_r;
  logic keep_r;
  logic q_valid, q_ready;
  ecdt_pkg::cmd_word_t q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= 16'd1;
      keep_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ecdt_pkg::CFG_CLOCK_REVISION) rev_r <= cfg_data;
      if (cfg_index == ecdt_pkg::CFG_KEEP_RUNNING) keep_r <= cfg_data[0];
    end
  end

  ecdt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_slot, .in_delay,
    .in_deadline, .in_request_revision, .clock_revision(rev_r),
    .q_valid, .q_ready, .q_word
  );

  ecdt_back #(.SLOTS(SLOTS), .LOW_COUNT_WIDTH(LOW_COUNT_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_word, .keep_running(keep_r),
    .out_valid, .out_ready, .out_status, .out_slot_out, .out_count_value,
    .out_last
  );

endmodule

[hdl/ecdt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdt_front
// Accepts input words, checks the revision and queues them for the back end.
// ----------------------------------------------------------------------------
module ecdt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ecdt_pkg::CmdW-1:0]           in_cmd,
  input  logic [ecdt_pkg::SlotW-1:0]          in_slot,
  input  logic [ecdt_pkg::DelayW-1:0]         in_delay,
  input  logic [ecdt_pkg::DeadlineW-1:0]      in_deadline,
  input  logic [ecdt_pkg::RevW-1:0]           in_request_revision,
  input  logic [ecdt_pkg::RevW-1:0]           clock_revision,
  output logic                                q_valid,
  input  logic                                q_ready,
  output ecdt_pkg::cmd_word_t                 q_word
);

  ecdt_pkg::cmd_word_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  ecdt_pkg::cmd_word_t w;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_word = mem_r[rp_r];

  always_comb begin
    w.cmd = in_cmd;
    w.slot = in_slot;
    w.delay = in_delay;
    w.deadline = in_deadline;
    w.rev_ok = (in_request_revision == '0) || (in_request_revision == clock_revision);
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= w;
    end
  end

endmodule

[hdl/ecdt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdt_back
// Holds the count and the slot table, executes commands and scans expiries.
// ----------------------------------------------------------------------------
module ecdt_back #(
  parameter int SLOTS = 16,
  parameter int LOW_COUNT_WIDTH = 24
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_valid,
  output logic                                          q_ready,
  input  ecdt_pkg::cmd_word_t                           q_word,
  input  logic                                          keep_running,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [ecdt_pkg::StatusW-1:0]                  out_status,
  output logic [ecdt_pkg::SlotW-1:0]                    out_slot_out,
  output logic [LOW_COUNT_WIDTH+ecdt_pkg::HighCountW-1:0] out_count_value,
  output logic                                          out_last
);

  localparam int CountW = LOW_COUNT_WIDTH + ecdt_pkg::HighCountW;
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t state_r;
  logic [CountW-1:0] count_r;
  logic [SLOTS-1:0] pend_r;
  logic [63:0] dl_r [SLOTS];
  logic [IdxW-1:0] idx_r, best_r;
  logic best_ok_r;
  logic [63:0] best_dl_r;
  logic [4:0] nexp_r;
  logic [ecdt_pkg::SlotW-1:0] stg_r;
  logic ovalid_r, olast_r;
  logic [ecdt_pkg::StatusW-1:0] ostat_r;
  logic [ecdt_pkg::SlotW-1:0] oslot_r;

  logic out_free, slot_in, emit;
  logic [IdxW-1:0] sidx;
  logic [63:0] cnt64, when_v, dl_i;
  logic cand;

  assign out_free = !ovalid_r || out_ready;
  assign q_ready = (state_r == S_IDLE) && out_free;
  assign out_valid = ovalid_r;
  assign out_status = ostat_r;
  assign out_slot_out = oslot_r;
  assign out_count_value = count_r;
  assign out_last = olast_r;

  always_comb begin
    slot_in = ({{(32-ecdt_pkg::SlotW){1'b0}}, q_word.slot} < 32'(SLOTS));
    sidx = IdxW'(q_word.slot);
    cnt64 = 64'(count_r);
    when_v = (q_word.delay != '0) ? cnt64 + 64'(q_word.delay) : q_word.deadline;
    dl_i = dl_r[idx_r];
    cand = pend_r[idx_r] && (dl_i <= cnt64) && (!best_ok_r || dl_i < best_dl_r);
    emit = out_free &&
           (((state_r == S_IDLE) && q_valid && (q_word.cmd != ecdt_pkg::CMD_TICK)) ||
            ((state_r == S_EMIT) && (nexp_r != '0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r <= '0;
      ovalid_r <= 1'b0;
      idx_r <= '0;
      best_ok_r <= 1'b0;
      nexp_r <= '0;
    end else begin
      ovalid_r <= emit || (ovalid_r && !out_ready);
      case (state_r)
        S_IDLE: begin
          if (q_valid && out_free) begin
            case (q_word.cmd)
              ecdt_pkg::CMD_TICK: begin
                if ((pend_r != '0) || keep_running) count_r <= count_r + 1'b1;
                idx_r <= '0;
                best_ok_r <= 1'b0;
                nexp_r <= '0;
                state_r <= S_SCAN;
              end
              ecdt_pkg::CMD_REQUEST: begin
                olast_r <= 1'b1;
                oslot_r <= q_word.slot;
                if (!q_word.rev_ok) begin
                  ostat_r <= ecdt_pkg::ST_STALE;
                end else if (!slot_in || pend_r[sidx]) begin
                  ostat_r <= ecdt_pkg::ST_BUSY;
                end else if (when_v <= cnt64) begin
                  ostat_r <= ecdt_pkg::ST_PASSED;
                end else begin
                  ostat_r <= ecdt_pkg::ST_ACCEPTED;
                  pend_r[sidx] <= 1'b1;
                  dl_r[sidx] <= when_v;
                end
              end
              ecdt_pkg::CMD_CANCEL: begin
                olast_r <= 1'b1;
                oslot_r <= q_word.slot;
                if (slot_in && pend_r[sidx]) begin
                  pend_r[sidx] <= 1'b0;
                  ostat_r <= ecdt_pkg::ST_CANCELLED;
                end else begin
                  ostat_r <= ecdt_pkg::ST_NOT_PENDING;
                end
              end
              default: begin
                olast_r <= 1'b1;
                ostat_r <= ecdt_pkg::ST_COUNT;
                oslot_r <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cand) begin
            best_ok_r <= 1'b1;
            best_r <= idx_r;
            best_dl_r <= dl_i;
          end
          if (32'(idx_r) == SLOTS - 1) begin
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (!best_ok_r && (nexp_r == '0)) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            if (nexp_r != '0) begin
              ostat_r <= ecdt_pkg::ST_EXPIRED;
              oslot_r <= stg_r;
              olast_r <= !best_ok_r;
            end
            if (!best_ok_r) begin
              state_r <= S_IDLE;
            end else begin
              pend_r[best_r] <= 1'b0;
              stg_r <= ecdt_pkg::SlotW'(best_r);
              nexp_r <= nexp_r + 1'b1;
              best_ok_r <= 1'b0;
              if (nexp_r != 5'd15) begin
                idx_r <= '0;
                state_r <= S_SCAN;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/ecdt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdt_checker
// Port-level checks on the timer's result channel.
// ----------------------------------------------------------------------------
module ecdt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_last,
  input logic [3:0] out_slot_out
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word changed while stalled");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ecdt_pkg::ST_EXPIRED |-> out_last)
    else $error("non-expiry result without last");

  a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ecdt_pkg::ST_COUNT |-> out_slot_out == 4'd0)
    else $error("read result with nonzero slot");

endmodule

bind extended_counter_deadline_timer ecdt_checker u_ecdt_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_last, .out_slot_out
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deadline timer with the extended tick count.
// A directed table covers the corner cases, then random requests, ticks,
// cancels and reads run under several revision and keep-running settings.
// Every result word is checked against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module tb;

  localparam int CountW = 24 + ecdt_pkg::HighCountW;
  localparam int NumSlots = 16;

  typedef struct {
    logic [ecdt_pkg::StatusW-1:0] status;
    logic [ecdt_pkg::SlotW-1:0]   slot;
    logic [CountW-1:0]            count;
    logic                         last;
  } timer_word_t;

  typedef struct {
    logic [ecdt_pkg::CmdW-1:0]      cmd;
    logic [ecdt_pkg::SlotW-1:0]     slot;
    logic [ecdt_pkg::DelayW-1:0]    delay;
    logic [ecdt_pkg::DeadlineW-1:0] deadline;
    logic [ecdt_pkg::RevW-1:0]      rev;
    bit                             has_exp;
    logic [ecdt_pkg::StatusW-1:0]   exp_status;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [ecdt_pkg::CmdW-1:0] in_cmd;
  logic [ecdt_pkg::SlotW-1:0] in_slot;
  logic [ecdt_pkg::DelayW-1:0] in_delay;
  logic [ecdt_pkg::DeadlineW-1:0] in_deadline;
  logic [ecdt_pkg::RevW-1:0] in_request_revision;
  logic out_valid, out_ready;
  logic [ecdt_pkg::StatusW-1:0] out_status;
  logic [ecdt_pkg::SlotW-1:0] out_slot_out;
  logic [CountW-1:0] out_count_value;
  logic out_last;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [ecdt_pkg::RevW-1:0] cfg_data;

  logic [CountW-1:0] mdl_count;
  logic [NumSlots-1:0] mdl_pending;
  logic [ecdt_pkg::DeadlineW-1:0] mdl_deadline [NumSlots];
  logic [ecdt_pkg::RevW-1:0] mdl_rev;
  logic mdl_keep;

  timer_word_t due_words[$];
  int errors;
  bit no_idle;
  int out_stall;

  extended_counter_deadline_timer u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic timer_predict(input logic [ecdt_pkg::CmdW-1:0] cmd,
                               input logic [ecdt_pkg::SlotW-1:0] slot,
                               input logic [ecdt_pkg::DelayW-1:0] delay,
                               input logic [ecdt_pkg::DeadlineW-1:0] deadline,
                               input logic [ecdt_pkg::RevW-1:0] rev);
    timer_word_t w;
    logic [ecdt_pkg::DeadlineW-1:0] when;
    int best, n;
    n = 0;
    w.slot = slot;
    w.last = 1'b1;
    case (cmd)
      ecdt_pkg::CMD_TICK: begin
        if (mdl_pending != '0 || mdl_keep) mdl_count = mdl_count + 1'b1;
        forever begin
          best = -1;
          for (int i = 0; i < NumSlots; i++) begin
            if (mdl_pending[i] && mdl_deadline[i] <= {8'd0, mdl_count} &&
                (best < 0 || mdl_deadline[i] < mdl_deadline[best])) best = i;
          end
          if (best < 0 || n >= NumSlots) break;
          mdl_pending[best] = 1'b0;
          w.status = ecdt_pkg::ST_EXPIRED;
          w.slot = ecdt_pkg::SlotW'(best);
          w.count = mdl_count;
          w.last = 1'b0;
          due_words.push_back(w);
          n++;
        end
        if (n > 0) due_words[$].last = 1'b1;
        return;
      end
      ecdt_pkg::CMD_REQUEST: begin
        if (rev != 0 && rev != mdl_rev) begin
          w.status = ecdt_pkg::ST_STALE;
        end else if (mdl_pending[slot]) begin
          w.status = ecdt_pkg::ST_BUSY;
        end else begin
          when = (delay != 0) ? {8'd0, mdl_count} + delay : deadline;
          if (when <= {8'd0, mdl_count}) begin
            w.status = ecdt_pkg::ST_PASSED;
          end else begin
            mdl_deadline[slot] = when;
            mdl_pending[slot] = 1'b1;
            w.status = ecdt_pkg::ST_ACCEPTED;
          end
        end
      end
      ecdt_pkg::CMD_CANCEL: begin
        w.status = mdl_pending[slot] ? ecdt_pkg::ST_CANCELLED : ecdt_pkg::ST_NOT_PENDING;
        mdl_pending[slot] = 1'b0;
      end
      default: begin
        w.status = ecdt_pkg::ST_COUNT;
        w.slot = '0;
      end
    endcase
    w.count = mdl_count;
    due_words.push_back(w);
  endtask

  task automatic send_word(input logic [ecdt_pkg::CmdW-1:0] cmd,
                           input logic [ecdt_pkg::SlotW-1:0] slot,
                           input logic [ecdt_pkg::DelayW-1:0] delay,
                           input logic [ecdt_pkg::DeadlineW-1:0] deadline,
                           input logic [ecdt_pkg::RevW-1:0] rev);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_slot <= slot;
    in_delay <= delay;
    in_deadline <= deadline;
    in_request_revision <= rev;
    do @(posedge clk); while (!in_ready);
    timer_predict(cmd, slot, delay, deadline, rev);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ecdt_pkg::RevW-1:0] data);
    drain_and_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ecdt_pkg::CFG_CLOCK_REVISION) mdl_rev = data;
    else mdl_keep = data[0];
  endtask

  task automatic random_word();
    logic [ecdt_pkg::CmdW-1:0] cmd;
    logic [ecdt_pkg::DelayW-1:0] delay;
    logic [ecdt_pkg::DeadlineW-1:0] deadline;
    logic [ecdt_pkg::RevW-1:0] rev;
    int r;
    r = $urandom_range(0, 99);
    cmd = (r < 40) ? ecdt_pkg::CMD_TICK :
          (r < 75) ? ecdt_pkg::CMD_REQUEST :
          (r < 88) ? ecdt_pkg::CMD_CANCEL : ecdt_pkg::CMD_READ;
    r = $urandom_range(0, 9);
    rev = (r < 4) ? 16'd0 : (r < 8) ? mdl_rev : ecdt_pkg::RevW'($urandom);
    r = $urandom_range(0, 9);
    delay = 0;
    deadline = {$urandom, $urandom};
    if (r < 5) delay = $urandom_range(1, 8);
    else if (r < 8) deadline = {8'd0, mdl_count} + $urandom_range(0, 8) - 2;
    else if (r < 9) delay = $urandom;
    send_word(cmd, 4'($urandom), delay, deadline, rev);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word status=%0d slot=%0d", $time, out_status, out_slot_out);
        errors++;
      end else begin
        timer_word_t e;
        e = due_words.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d act %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_slot_out !== e.slot) begin
          $display("%0t: slot exp %0d act %0d", $time, e.slot, out_slot_out);
          errors++;
        end
        if (out_count_value !== e.count) begin
          $display("%0t: count exp %0h act %0h", $time, e.count, out_count_value);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last exp %0b act %0b", $time, e.last, out_last);
          errors++;
        end
      end
      out_stall = no_idle ? 0 : $urandom_range(0, 11);
    end
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  stim_row_t rows[$];

  initial begin
    errors = 0;
    no_idle = 0;
    out_stall = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = ecdt_pkg::CMD_READ;
    in_slot = '0;
    in_delay = '0;
    in_deadline = '0;
    in_request_revision = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ecdt_pkg::CFG_CLOCK_REVISION;
    cfg_data = '0;
    mdl_count = '0;
    mdl_pending = '0;
    mdl_rev = 16'd1;
    mdl_keep = 1'b0;
    for (int i = 0; i < NumSlots; i++) mdl_deadline[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{ecdt_pkg::CMD_READ, 0, 0, 0, 0, 1, ecdt_pkg::ST_COUNT},
      '{ecdt_pkg::CMD_TICK, 0, 0, 0, 0, 0, ecdt_pkg::ST_COUNT},
      '{ecdt_pkg::CMD_REQUEST, 0, 0, 5, 16'hffff, 1, ecdt_pkg::ST_STALE},
      '{ecdt_pkg::CMD_REQUEST, 0, 0, 0, 0, 1, ecdt_pkg::ST_PASSED},
      '{ecdt_pkg::CMD_REQUEST, 0, 0, 3, 1, 1, ecdt_pkg::ST_ACCEPTED},
      '{ecdt_pkg::CMD_REQUEST, 0, 5, 0, 0, 1, ecdt_pkg::ST_BUSY},
      '{ecdt_pkg::CMD_REQUEST, 1, 0, 3, 0, 1, ecdt_pkg::ST_ACCEPTED},
      '{ecdt_pkg::CMD_REQUEST, 15, 32'hffffffff, 0, 0, 1, ecdt_pkg::ST_ACCEPTED},
      '{ecdt_pkg::CMD_REQUEST, 14, 0, 64'hffffffffffffffff, 0, 1, ecdt_pkg::ST_ACCEPTED},
      '{ecdt_pkg::CMD_REQUEST, 2, 1, 0, 0, 1, ecdt_pkg::ST_ACCEPTED},
      '{ecdt_pkg::CMD_TICK, 0, 0, 0, 0, 0, ecdt_pkg::ST_COUNT},
      '{ecdt_pkg::CMD_TICK, 0, 0, 0, 0, 0, ecdt_pkg::ST_COUNT},
      '{ecdt_pkg::CMD_TICK, 0, 0, 0, 0, 0, ecdt_pkg::ST_COUNT},
      '{ecdt_pkg::CMD_CANCEL, 15, 0, 0, 0, 1, ecdt_pkg::ST_CANCELLED},
      '{ecdt_pkg::CMD_CANCEL, 15, 0, 0, 0, 1, ecdt_pkg::ST_NOT_PENDING},
      '{ecdt_pkg::CMD_CANCEL, 14, 0, 0, 0, 1, ecdt_pkg::ST_CANCELLED},
      '{ecdt_pkg::CMD_REQUEST, 3, 0, 64'h00ffffffffffffff, 1, 1, ecdt_pkg::ST_ACCEPTED},
      '{ecdt_pkg::CMD_CANCEL, 3, 0, 0, 0, 1, ecdt_pkg::ST_CANCELLED},
      '{ecdt_pkg::CMD_TICK, 0, 0, 0, 0, 0, ecdt_pkg::ST_COUNT},
      '{ecdt_pkg::CMD_READ, 0, 0, 0, 0, 0, ecdt_pkg::ST_COUNT}
    };
    foreach (rows[i]) begin
      send_word(rows[i].cmd, rows[i].slot, rows[i].delay, rows[i].deadline, rows[i].rev);
      if (rows[i].has_exp && due_words[$].status !== rows[i].exp_status) begin
        $display("%0t: row %0d status exp %0d act %0d", $time, i, rows[i].exp_status,
                 due_words[$].status);
        errors++;
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(ecdt_pkg::CFG_KEEP_RUNNING, 16'd1);
          write_reg(ecdt_pkg::CFG_CLOCK_REVISION, 16'hffff);
        end
        1: begin
          write_reg(ecdt_pkg::CFG_KEEP_RUNNING, 16'd0);
          write_reg(ecdt_pkg::CFG_CLOCK_REVISION, 16'd0);
        end
        2: write_reg(ecdt_pkg::CFG_CLOCK_REVISION, 16'h5a5a);
        default: begin
          write_reg(ecdt_pkg::CFG_KEEP_RUNNING, 16'd1);
          write_reg(ecdt_pkg::CFG_CLOCK_REVISION, 16'd1);
        end
      endcase
      no_idle = (phase == 2);
      for (int k = 0; k < 10; k++) random_word();
      no_idle = 0;
      for (int s = 0; s < NumSlots; s++) send_word(ecdt_pkg::CMD_CANCEL, s, 0, 0, 0);
      for (int k = 0; k < 3; k++) random_word();
    end

    drain_and_idle();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
